FILE: sv/ncc_pkg.sv
// Shared constants, types and exp tables for the nearest-centroid classifier.
// No dependencies; every other file but ncc_ram uses this package.
package ncc_pkg;

    localparam int MAX_CLASSES = 16;
    localparam int MAX_DIMS    = 64;
    localparam int VALUE_BITS  = 32;

    localparam int CLS_W   = $clog2(MAX_CLASSES);
    localparam int DIM_W   = $clog2(MAX_DIMS);
    localparam int ADDR_W  = CLS_W + DIM_W;
    localparam int ACC_W   = 64;
    localparam int POST_W  = 17;
    localparam int CNT_W   = DIM_W + 1;
    localparam int NUM_W   = 5;
    localparam int SUM_W   = 21;
    localparam int NUMER_W = 33;
    localparam int IDX_W   = CLS_W + 1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Control that every cell of the ring sees
    typedef struct packed {
        logic acc_shift;
        logic acc_clr;
        logic w_shift;
    } t_cell_ctl;

    // exp(-i), Q1.16
    function automatic logic [16:0] exp_int(input logic [3:0] i);
        logic [16:0] r;
        case (i)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd24109;
            4'd2:    r = 17'd8869;
            4'd3:    r = 17'd3263;
            4'd4:    r = 17'd1200;
            4'd5:    r = 17'd442;
            4'd6:    r = 17'd162;
            4'd7:    r = 17'd60;
            4'd8:    r = 17'd22;
            4'd9:    r = 17'd8;
            4'd10:   r = 17'd3;
            4'd11:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // exp(-f/16), Q1.16
    function automatic logic [16:0] exp_frac(input logic [3:0] f);
        logic [16:0] r;
        case (f)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd61565;
            4'd2:    r = 17'd57835;
            4'd3:    r = 17'd54331;
            4'd4:    r = 17'd51039;
            4'd5:    r = 17'd47947;
            4'd6:    r = 17'd45042;
            4'd7:    r = 17'd42313;
            4'd8:    r = 17'd39750;
            4'd9:    r = 17'd37341;
            4'd10:   r = 17'd35079;
            4'd11:   r = 17'd32954;
            4'd12:   r = 17'd30957;
            4'd13:   r = 17'd29081;
            4'd14:   r = 17'd27319;
            default: r = 17'd25664;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/ncc_in_if.sv
// Input channel: mean writes and sample elements.
// Depends on ncc_pkg.
interface ncc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [ncc_pkg::CLS_W-1:0]           mean_class;
    logic [ncc_pkg::DIM_W-1:0]           dim_index;
    logic signed [ncc_pkg::VALUE_BITS-1:0] value;
    logic                                last_element;

    modport source (output valid, opcode, mean_class, dim_index, value, last_element,
                    input ready);
    modport sink   (input valid, opcode, mean_class, dim_index, value, last_element,
                    output ready);
endinterface

FILE: sv/ncc_out_if.sv
// Output channel: one posterior beat per class.
// Depends on ncc_pkg.
interface ncc_out_if;
    logic                         valid;
    logic                         ready;
    logic [ncc_pkg::CLS_W-1:0]    class_id;
    logic [ncc_pkg::POST_W-1:0]   posterior;
    logic [ncc_pkg::CLS_W-1:0]    best_class;
    logic                         last_result;

    modport source (output valid, class_id, posterior, best_class, last_result,
                    input ready);
    modport sink   (input valid, class_id, posterior, best_class, last_result,
                    output ready);
endinterface

FILE: sv/nearest_centroid_softmax_classifier_top.sv
// Channel  Dir  Payload                                          Handshake
// i_in     in   opcode, mean_class, dim_index, value, last_elem  valid/ready
// o_out    out  class_id, posterior, best_class, last_result     valid/ready
// cfg      in   num_classes (5 bits)                             i_cfg_we
//
// A sample element turns the 16-cell accumulator ring once through the
// shared squarer. The last element adds a min pass, a weight pass and a
// serial divider pass per active class, then one beat per active class.
// Reset is synchronous; the mean RAM is not cleared. Input stalls while busy;
// output stalls hold the result register.
// Depends on ncc_pkg, ncc_in_if, ncc_out_if, ncc_ram, ncc_cell, ncc_div.
module nearest_centroid_softmax_classifier_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [ncc_pkg::NUM_W-1:0] i_cfg_data,
    ncc_in_if.sink                   i_in,
    ncc_out_if.source                o_out
);
    import ncc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ACC, ST_MIN, ST_WGT, ST_DIV, ST_OUT
    } t_state;

    t_state             r_state;
    logic [NUM_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_cnt;
    logic signed [VALUE_BITS-1:0] r_val;
    logic               r_last;
    logic [IDX_W-1:0]   r_iss;
    logic [IDX_W-1:0]   r_k;
    logic               r_rd_v, r_abs_v, r_sq_v;
    logic [CLS_W-1:0]   r_rd_c;
    logic [VALUE_BITS-1:0] r_abs;
    logic [ACC_W-1:0]   r_sq;
    logic [ACC_W-1:0]   r_min;
    logic               r_wv, r_wz;
    logic [3:0]         r_ip, r_fr;
    logic [IDX_W-1:0]   r_push;
    logic [SUM_W-1:0]   r_sum;
    logic               r_dwait;
    logic [CLS_W-1:0]   r_best;
    logic [POST_W-1:0]  r_bestp;
    logic               r_ov;
    logic [CLS_W-1:0]   r_oc;
    logic [POST_W-1:0]  r_op;
    logic [CLS_W-1:0]   r_ob;
    logic               r_ol;

    logic [VALUE_BITS-1:0] mean_rd;
    logic [ADDR_W-1:0]  raddr;
    logic               accept, mean_we;
    logic [ACC_W-1:0]   acc [MAX_CLASSES];
    logic [POST_W-1:0]  wgt [MAX_CLASSES];
    logic [ACC_W-1:0]   acc_tail;
    logic [POST_W-1:0]  w_tail;
    t_cell_ctl          ctl;
    logic [ACC_W:0]     sat_sum;
    logic [ACC_W-1:0]   delta;
    logic signed [VALUE_BITS:0] diff;
    logic [33:0]        wprod;
    logic [34:0]        wrnd;
    logic [POST_W-1:0]  wval;
    logic               k_act, div_start, div_done, div_rot, out_load, out_last;
    logic [POST_W-1:0]  quot;
    logic [NUMER_W-1:0] numer;

    assign accept  = i_in.valid && i_in.ready;
    assign mean_we = accept && (i_in.opcode == OP_WRITE);
    assign i_in.ready = (r_state == ST_IDLE);

    ncc_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_CLASSES * MAX_DIMS)) u_mean (
        .i_clk   (i_clk),
        .i_we    (mean_we),
        .i_waddr ({i_in.mean_class, i_in.dim_index}),
        .i_wdata (i_in.value),
        .i_raddr (raddr),
        .o_rdata (mean_rd)
    );

    assign raddr = {r_iss[CLS_W-1:0], r_cnt[DIM_W-1:0]};

    // datapath helpers
    assign diff    = {r_val[VALUE_BITS-1], r_val} - {mean_rd[VALUE_BITS-1], mean_rd};
    assign sat_sum = {1'b0, acc[0]} + {1'b0, r_sq};
    assign delta   = acc[0] - r_min;
    assign wprod   = exp_int(r_ip) * exp_frac(r_fr);
    assign wrnd    = {1'b0, wprod} + 35'd32768;
    assign wval    = r_wz ? '0 : wrnd[32:16];
    assign k_act   = ({1'b0, r_k[CLS_W-1:0]} < r_n) && !r_k[CLS_W];
    assign numer   = {wgt[0], 16'd0} + NUMER_W'(r_sum >> 1);

    // divider sequencing and output loading
    assign div_start = (r_state == ST_DIV) && !r_dwait && k_act;
    assign div_rot   = (r_state == ST_DIV) && ((!r_dwait && !k_act) || (r_dwait && div_done));
    assign out_load  = (r_state == ST_OUT) && (!r_ov || o_out.ready);
    assign out_last  = out_load && (r_k == IDX_W'(r_n - 1'b1));

    ncc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (numer),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // ring control
    always_comb begin
        ctl.acc_shift = ((r_state == ST_ACC) && r_sq_v) || (r_state == ST_MIN)
                        || ((r_state == ST_WGT) && !r_k[CLS_W]);
        ctl.acc_clr   = out_last;
        ctl.w_shift   = ((r_state == ST_WGT) && r_wv) || div_rot || out_load;
        if (r_state == ST_ACC) begin
            acc_tail = sat_sum[ACC_W] ? '1 : sat_sum[ACC_W-1:0];
        end else begin
            acc_tail = acc[0];
        end
        case (r_state)
            ST_WGT:  w_tail = wval;
            ST_DIV:  w_tail = r_dwait ? quot : '0;
            default: w_tail = '0;
        endcase
    end

    // chain of cells; cell 0 is the head
    for (genvar g = 0; g < MAX_CLASSES; g++) begin : g_cell
        ncc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_acc   ((g == MAX_CLASSES - 1) ? acc_tail : acc[(g + 1) % MAX_CLASSES]),
            .i_w     ((g == MAX_CLASSES - 1) ? w_tail : wgt[(g + 1) % MAX_CLASSES]),
            .o_acc   (acc[g]),
            .o_w     (wgt[g])
        );
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= NUM_W'(2);
            r_cnt   <= '0;
            r_rd_v  <= 1'b0;
            r_abs_v <= 1'b0;
            r_sq_v  <= 1'b0;
            r_wv    <= 1'b0;
            r_dwait <= 1'b0;
            r_ov    <= 1'b0;
            r_k     <= '0;
            r_iss   <= '0;
            r_push  <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_data < NUM_W'(2)) begin
                    r_n <= NUM_W'(2);
                end else if (i_cfg_data > NUM_W'(MAX_CLASSES)) begin
                    r_n <= NUM_W'(MAX_CLASSES);
                end else begin
                    r_n <= i_cfg_data;
                end
            end

            if (out_load) begin
                r_ov <= 1'b1;
                r_oc <= r_k[CLS_W-1:0];
                r_op <= wgt[0];
                r_ob <= r_best;
                r_ol <= out_last;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_in.opcode == OP_SAMPLE) begin
                        r_val  <= i_in.value;
                        r_last <= i_in.last_element;
                        r_k    <= '0;
                        r_iss  <= '0;
                        if (r_cnt < CNT_W'(MAX_DIMS)) begin
                            r_state <= ST_ACC;
                        end else if (i_in.last_element) begin
                            r_state <= ST_MIN;
                        end
                    end
                end
                ST_ACC: begin
                    // read, abs, square, add: one class per cycle
                    r_rd_v <= !r_iss[CLS_W];
                    if (!r_iss[CLS_W]) begin
                        r_rd_c <= r_iss[CLS_W-1:0];
                        r_iss  <= r_iss + 1'b1;
                    end
                    r_abs_v <= r_rd_v;
                    if ({1'b0, r_rd_c} < r_n) begin
                        r_abs <= diff[VALUE_BITS] ? VALUE_BITS'(-diff)
                                                  : diff[VALUE_BITS-1:0];
                    end else begin
                        r_abs <= '0;
                    end
                    r_sq_v <= r_abs_v;
                    r_sq   <= r_abs * r_abs;
                    if (r_sq_v) begin
                        r_k <= r_k + 1'b1;
                        if (r_k == IDX_W'(MAX_CLASSES - 1)) begin
                            r_cnt <= r_cnt + 1'b1;
                            r_k   <= '0;
                            r_state <= r_last ? ST_MIN : ST_IDLE;
                        end
                    end
                end
                ST_MIN: begin
                    if (r_k == '0 || (k_act && acc[0] < r_min)) begin
                        r_min <= acc[0];
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == IDX_W'(MAX_CLASSES - 1)) begin
                        r_k     <= '0;
                        r_push  <= '0;
                        r_sum   <= '0;
                        r_wv    <= 1'b0;
                        r_state <= ST_WGT;
                    end
                end
                ST_WGT: begin
                    // index the exp tables, then multiply into the weight ring
                    r_wv <= !r_k[CLS_W];
                    if (!r_k[CLS_W]) begin
                        r_wz <= !k_act || (|delta[ACC_W-1:37]);
                        r_ip <= delta[36:33];
                        r_fr <= delta[32:29];
                        r_k  <= r_k + 1'b1;
                    end
                    if (r_wv) begin
                        r_sum  <= r_sum + SUM_W'(wval);
                        r_push <= r_push + 1'b1;
                        if (r_push == IDX_W'(MAX_CLASSES - 1)) begin
                            r_k     <= '0;
                            r_dwait <= 1'b0;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_start) begin
                        r_dwait <= 1'b1;
                    end
                    if (div_rot) begin
                        r_dwait <= 1'b0;
                        if (r_dwait && (r_k == '0 || quot > r_bestp)) begin
                            r_bestp <= quot;
                            r_best  <= r_k[CLS_W-1:0];
                        end
                        r_k <= r_k + 1'b1;
                        if (r_k == IDX_W'(MAX_CLASSES - 1)) begin
                            r_k     <= '0;
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_k <= r_k + 1'b1;
                        if (out_last) begin
                            r_cnt   <= '0;
                            r_k     <= '0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.class_id    = r_oc;
    assign o_out.posterior   = r_op;
    assign o_out.best_class  = r_ob;
    assign o_out.last_result = r_ol;

    a_last_is_final_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && out_last) |-> (r_k[CLS_W-1:0] == CLS_W'(r_n - 1'b1)))
        else $error("last result not on final class");

    a_sum_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_sum >= SUM_W'(65536)))
        else $error("weight sum below the winner weight");

    a_post_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (wgt[0] <= POST_W'(65536)))
        else $error("posterior out of range");
endmodule

FILE: sv/ncc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ncc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/ncc_cell.sv
// One ring cell: a class distance accumulator and a class weight slot.
// Depends on ncc_pkg.
module ncc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ncc_pkg::t_cell_ctl        i_ctl,
    input  logic [ncc_pkg::ACC_W-1:0] i_acc,
    input  logic [ncc_pkg::POST_W-1:0] i_w,
    output logic [ncc_pkg::ACC_W-1:0] o_acc,
    output logic [ncc_pkg::POST_W-1:0] o_w
);
    import ncc_pkg::*;

    logic [ACC_W-1:0]  r_acc;
    logic [POST_W-1:0] r_w;

    // accumulator: cleared by reset and after each sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_shift) begin
            r_acc <= i_acc;
        end
    end

    // weight / posterior slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.w_shift) begin
            r_w <= i_w;
        end
    end

    assign o_acc = r_acc;
    assign o_w   = r_w;
endmodule

FILE: sv/ncc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ncc_pkg.
module ncc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ncc_pkg::NUMER_W-1:0] i_num,
    input  logic [ncc_pkg::SUM_W-1:0]   i_den,
    output logic                        o_done,
    output logic [ncc_pkg::POST_W-1:0]  o_quot
);
    import ncc_pkg::*;

    localparam int STEP_W = $clog2(NUMER_W + 1);

    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_done;
    logic [NUMER_W-1:0] r_num;
    logic [SUM_W-1:0]   r_den;
    logic [SUM_W-1:0]   r_rem;
    logic [POST_W-1:0]  r_q;
    logic [SUM_W:0]     trial;
    logic               take;

    assign trial = {r_rem, r_num[NUMER_W-1]};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= take ? SUM_W'(trial - {1'b0, r_den}) : trial[SUM_W-1:0];
                r_q   <= {r_q[POST_W-2:0], take};
                r_num <= {r_num[NUMER_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUMER_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
endmodule
